### design/nlmd_pkg.sv
// Shared types and constants of the non-local-means denoiser.
package nlmd_pkg;

   localparam int PIX_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int IW_W       = 11;
   localparam int IH_W       = 13;
   localparam int SR_W       = 4;
   localparam int PR_W       = 2;
   localparam int IS_W       = 32;
   localparam int PSPAN_W    = 3;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [IW_W-1:0] IMAGE_WIDTH_RESET   = 11'd1024;
   localparam logic [IH_W-1:0] IMAGE_HEIGHT_RESET  = 13'd768;
   localparam logic [SR_W-1:0] SEARCH_RADIUS_RESET = 4'd5;
   localparam logic [PR_W-1:0] PATCH_RADIUS_RESET  = 2'd2;
   localparam logic [IS_W-1:0] INV_SIGMA_SQ_RESET  = 32'd6711;

   // Q30 constants of the exponential
   localparam logic [31:0] Q30_ONE    = 32'd1073741824;
   localparam logic [31:0] Q30_INV_E  = 32'd395007542;
   localparam logic [63:0] Q30_HALF   = 64'd536870912;
   localparam logic [3:0]  TAYLOR_TOP = 4'd12;

   // ceil(2^33 / b) for the odd parts of the Taylor divisors; exact below 2^30
   localparam logic [31:0] RECIP_ONE = 32'd1;
   localparam logic [31:0] RECIP_3   = 32'd2863311531;
   localparam logic [31:0] RECIP_5   = 32'd1717986919;
   localparam logic [31:0] RECIP_7   = 32'd1227133514;
   localparam logic [31:0] RECIP_9   = 32'd954437177;
   localparam logic [31:0] RECIP_11  = 32'd780903145;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_SEARCH_RADIUS = 3'd2,
      CSR_PATCH_RADIUS  = 3'd3,
      CSR_INV_SIGMA_SQ  = 3'd4
   } csr_index_type;

   // control shared by all cells of the centre-patch chain
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

### design/nlmd_patch_cell.sv
// One cell of the circulating centre-patch chain.
module nlmd_patch_cell (
   input  logic                       clock,
   input  nlmd_pkg::cell_ctl_type     ctl,
   input  logic                       is_tail,
   input  logic [nlmd_pkg::PIX_W-1:0] next_pixel,
   input  logic [nlmd_pkg::PIX_W-1:0] head_pixel,
   input  logic [nlmd_pkg::PIX_W-1:0] load_pixel,
   output logic [nlmd_pkg::PIX_W-1:0] pixel
);
   import nlmd_pkg::*;

   logic [PIX_W-1:0] pixel_ff;
   logic [PIX_W-1:0] pixel_in;

   // on a shift take the neighbour's pixel, the tail a fresh pixel or the head; else hold
   always_comb begin
      pixel_in = pixel_ff;
      if (ctl.shift) begin
         if (is_tail) begin
            pixel_in = ctl.load ? load_pixel : head_pixel;
         end else begin
            pixel_in = next_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

### design/nlmd_mul.sv
// 32 by 32 multiplier built from two 32 by 16 partial products.
module nlmd_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [63:0] prod
);
   import nlmd_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] prod_ff, prod_in;

   // latch operands, add low then high partial product
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      if (start) begin
         a_in     = a;
         b_in     = b;
         phase_in = 2'd1;
      end else if (phase_ff == 2'd1) begin
         prod_in  = 64'(a_ff * 48'(b_ff[15:0]));
         phase_in = 2'd2;
      end else if (phase_ff == 2'd2) begin
         prod_in  = prod_ff + {16'(0), 48'(a_ff * 48'(b_ff[31:16]))} * 64'd65536;
         phase_in = 2'd0;
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

### design/nlmd_div.sv
// Restoring divider, one quotient bit per cycle.
module nlmd_div #(
   parameter int N = 32,
   parameter int D = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);
   import nlmd_pkg::*;

   localparam int CNT_W = $clog2(N + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [D-1:0]     div_ff, div_in;
   logic [N-1:0]     quo_ff, quo_in;
   logic [D:0]       trial;
   logic [D:0]       diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[N-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   // shift in one dividend bit, subtract where the divisor fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(N);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[D-1:0] : trial[D-1:0];
         quo_in = {quo_ff[N-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/nonlocal_means_denoise_top.sv
// Non-local-means denoiser: line store, patch chain, weight unit and output stage.
// Takes one padded pixel per item; an item that completes no window is only stored.
// For a window pixel it weighs the patch of A = (2R+1)^2 pixels at each of O = (2S+1)^2
// offsets against the centre patch, n = exp shift; an offset with n >= 16 gets weight 1.
// The exponential uses twelve Taylor steps; a waiting result stalls the output stage.
// One item is in work at a time. Reset is synchronous: counters clear, configuration reloads.
module nonlocal_means_denoise_top #(
   parameter int MAX_WIDTH         = 1024,
   parameter int MAX_SEARCH_RADIUS = 10,
   parameter int MAX_PATCH_RADIUS  = 3,
   parameter int WEIGHT_FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nlmd_pkg::PIX_W-1:0]      req_tdata,   // padded_pixel
   input  logic                            req_tuser,   // frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nlmd_pkg::PIX_W-1:0]      rsp_tdata,   // denoised_pixel
   output logic                            rsp_tlast,   // frame_last
   input  logic                            csr_we,
   input  logic [nlmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nlmd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nlmd_pkg::*;

   localparam int PAD_MAX     = MAX_SEARCH_RADIUS + MAX_PATCH_RADIUS;
   localparam int STORE_COLS  = MAX_WIDTH + 2 * PAD_MAX;
   localparam int STORE_ROWS  = 2 * PAD_MAX + 1;
   localparam int STORE_DEPTH = STORE_ROWS * STORE_COLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(STORE_COLS + 1);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 2 * PAD_MAX + 1);
   localparam int SLOT_W      = $clog2(STORE_ROWS);
   localparam int SPAN_W      = $clog2(2 * MAX_SEARCH_RADIUS + 2);
   localparam int PATCH_CELLS = (2 * MAX_PATCH_RADIUS + 1) * (2 * MAX_PATCH_RADIUS + 1);
   localparam int CELL_W      = (PATCH_CELLS > 1) ? $clog2(PATCH_CELLS) : 1;
   localparam int D_W         = $clog2(PATCH_CELLS * 255 + 1);
   localparam int WT_W        = WEIGHT_FRAC_BITS
                                + $clog2((2 * MAX_SEARCH_RADIUS + 1)
                                         * (2 * MAX_SEARCH_RADIUS + 1) + 1);
   localparam int WTD_W       = WT_W + PIX_W;
   localparam int DIV_N       = (WTD_W + 1 > 30) ? WTD_W + 1 : 30;
   localparam int WF          = WEIGHT_FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SAD, S_DRAIN, S_WX, S_WXW, S_TM, S_TMW, S_TDW,
      S_R, S_EM, S_EMW, S_WF, S_ACC, S_Q, S_QW, S_EMIT
   } state_type;

   // configuration
   logic [IW_W-1:0] width_cfg_ff, width_cfg_in;
   logic [IH_W-1:0] height_cfg_ff, height_cfg_in;
   logic [SR_W-1:0] search_cfg_ff, search_cfg_in;
   logic [PR_W-1:0] patch_cfg_ff, patch_cfg_in;
   logic [IS_W-1:0] inv_cfg_ff, inv_cfg_in;

   // control and payload registers
   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COL_W-1:0] base_col_ff, base_col_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic             last_ff, last_in;
   logic [SPAN_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [PSPAN_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_load_ff, rd_load_in;
   logic             rd_ctr_ff, rd_ctr_in;
   logic [PIX_W-1:0] mem_q_ff;
   logic [D_W-1:0]   d_ff, d_in;
   logic [PIX_W-1:0] cand_ff, cand_in;
   logic [3:0]       n_ff, n_in;
   logic [23:0]      f_ff, f_in;
   logic [31:0]      term_ff, term_in, pos_ff, pos_in, neg_ff, neg_in, r_ff, r_in;
   logic [3:0]       k_ff, k_in;
   logic [WF-1:0]    w_ff, w_in;
   logic [WT_W-1:0]  wt_ff, wt_in;
   logic [WTD_W-1:0] wtd_ff, wtd_in;
   logic [PIX_W-1:0] q_ff, q_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   // derived configuration
   logic [COL_W-1:0]  width_eff, pad2, pw;
   logic [ROW_W-1:0]  height_eff, ph;
   logic [SPAN_W-1:0] s_eff, span_m1;
   logic [PR_W-1:0]   pr_eff;
   logic [PSPAN_W-1:0] pspan, pspan_m1;
   logic [CELL_W-1:0] len_m1;

   // memory ports
   logic [PIX_W-1:0]  line_mem [STORE_DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [COL_W-1:0]  rd_col;
   logic [SLOT_W:0]   rd_slot_sum;
   logic [SLOT_W-1:0] rd_slot;

   // arithmetic units
   logic              mul_start, mul_done;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_prod;
   logic              div_start, div_done;
   logic [DIV_N-1:0]  div_n, div_q;
   logic [WT_W-1:0]   div_d;
   logic [29:0]       tdiv_q;

   // patch chain
   cell_ctl_type      cell_ctl;
   logic [PIX_W-1:0]  cell_pix [PATCH_CELLS];
   logic [PIX_W-1:0]  head_pix, abs_diff;

   // accept-time values
   logic              restart, has_out;
   logic [COL_W-1:0]  c_cur, c_next;
   logic [ROW_W-1:0]  r_cur, r_next;
   logic [SLOT_W-1:0] slot_cur;
   logic [SLOT_W:0]   slot_wide;
   logic [63:0]       w_scaled, w_raw, w_top;

   // power-of-two part of a Taylor divisor
   function automatic logic [1:0] tdiv_shift(logic [3:0] k);
      logic [1:0] sh;
      case (k)
         4'd2, 4'd6, 4'd10: sh = 2'd1;
         4'd4, 4'd12:       sh = 2'd2;
         4'd8:              sh = 2'd3;
         default:           sh = 2'd0;
      endcase
      return sh;
   endfunction

   // reciprocal of the odd part of a Taylor divisor
   function automatic logic [31:0] tdiv_recip(logic [3:0] k);
      logic [31:0] rc;
      case (k)
         4'd3, 4'd6, 4'd12: rc = RECIP_3;
         4'd5, 4'd10:       rc = RECIP_5;
         4'd7:              rc = RECIP_7;
         4'd9:              rc = RECIP_9;
         4'd11:             rc = RECIP_11;
         default:           rc = RECIP_ONE;
      endcase
      return rc;
   endfunction

   // clamp configuration to the supported ranges
   always_comb begin
      if (width_cfg_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = COL_W'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         height_eff = ROW_W'(1);
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff = ROW_W'(height_cfg_ff);
      end
      if (32'(search_cfg_ff) > 32'(MAX_SEARCH_RADIUS)) begin
         s_eff = SPAN_W'(MAX_SEARCH_RADIUS);
      end else begin
         s_eff = SPAN_W'(search_cfg_ff);
      end
      if (32'(patch_cfg_ff) > 32'(MAX_PATCH_RADIUS)) begin
         pr_eff = PR_W'(MAX_PATCH_RADIUS);
      end else begin
         pr_eff = patch_cfg_ff;
      end
   end

   assign pad2     = COL_W'(2 * (32'(s_eff) + 32'(pr_eff)));
   assign pw       = width_eff + pad2;
   assign ph       = height_eff + ROW_W'(pad2);
   assign span_m1  = SPAN_W'({s_eff, 1'b0});
   assign pspan    = {pr_eff, 1'b1};
   assign pspan_m1 = {pr_eff, 1'b0};
   assign len_m1   = CELL_W'(6'(6'(pspan) * 6'(pspan)) - 6'd1);

   // read address of the current patch pixel
   assign rd_col      = base_col_ff + COL_W'(tx_ff) + COL_W'(dx_ff);
   assign rd_slot_sum = (SLOT_W+1)'(base_slot_ff) + (SLOT_W+1)'(ty_ff) + (SLOT_W+1)'(dy_ff);
   assign rd_slot     = (rd_slot_sum >= (SLOT_W+1)'(STORE_ROWS))
                        ? SLOT_W'(rd_slot_sum - (SLOT_W+1)'(STORE_ROWS))
                        : SLOT_W'(rd_slot_sum);
   assign mem_raddr   = ADDR_W'(rd_slot) * ADDR_W'(STORE_COLS) + ADDR_W'(rd_col);

   // position of the accepted pixel
   assign restart  = req_tuser || (col_ff >= pw) || (row_ff >= ph);
   assign c_cur    = restart ? '0 : col_ff;
   assign r_cur    = restart ? '0 : row_ff;
   assign slot_cur = restart ? '0 : slot_ff;
   assign c_next   = c_cur + 1'b1;
   assign r_next   = r_cur + 1'b1;
   assign has_out  = (c_cur >= pad2) && (r_cur >= ROW_W'(pad2));
   assign mem_waddr = ADDR_W'(slot_cur) * ADDR_W'(STORE_COLS) + ADDR_W'(c_cur);
   assign slot_wide = (slot_cur >= SLOT_W'(pad2))
                      ? (SLOT_W+1)'(slot_cur - SLOT_W'(pad2))
                      : (SLOT_W+1)'(slot_cur) + (SLOT_W+1)'(STORE_ROWS)
                        - (SLOT_W+1)'(pad2);

   // Taylor term quotient: plain shift, or reciprocal product scaled by 2^-33
   assign tdiv_q = (tdiv_recip(k_ff) == RECIP_ONE) ? mul_prod[29:0] : mul_prod[62:33];

   // weight rounding
   assign w_scaled = ({32'd0, r_ff} << WF) + Q30_HALF;
   assign w_raw    = w_scaled >> 30;
   assign w_top    = (64'd1 << WF) - 64'd1;

   assign head_pix = cell_pix[0];
   assign abs_diff = (mem_q_ff > head_pix) ? mem_q_ff - head_pix : head_pix - mem_q_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign mem_we     = req_tvalid && req_tready;

   // next-state and datapath
   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      search_cfg_in = search_cfg_ff;
      patch_cfg_in  = patch_cfg_ff;
      inv_cfg_in    = inv_cfg_ff;
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      slot_in       = slot_ff;
      base_col_in   = base_col_ff;
      base_slot_in  = base_slot_ff;
      last_in       = last_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      rd_vld_in     = 1'b0;
      rd_load_in    = 1'b0;
      rd_ctr_in     = 1'b0;
      d_in          = d_ff;
      cand_in       = cand_ff;
      n_in          = n_ff;
      f_in          = f_ff;
      term_in       = term_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      w_in          = w_ff;
      wt_in         = wt_ff;
      wtd_in        = wtd_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_n         = '0;
      div_d         = '0;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_cfg_in  = csr_wdata[IW_W-1:0];
            CSR_IMAGE_HEIGHT:  height_cfg_in = csr_wdata[IH_W-1:0];
            CSR_SEARCH_RADIUS: search_cfg_in = csr_wdata[SR_W-1:0];
            CSR_PATCH_RADIUS:  patch_cfg_in  = csr_wdata[PR_W-1:0];
            CSR_INV_SIGMA_SQ:  inv_cfg_in    = csr_wdata[IS_W-1:0];
            default: ;
         endcase
      end

      // accumulate the patch distance as candidate pixels return
      if (rd_vld_ff && !rd_load_ff) begin
         d_in = d_ff + D_W'(abs_diff);
         if (rd_ctr_ff) begin
            cand_in = mem_q_ff;
         end
      end

      // drop a result once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (c_next >= pw) begin
                  col_in = '0;
                  if (r_next >= ph) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = r_next;
                     slot_in = (slot_cur == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_cur + 1'b1;
                  end
               end else begin
                  col_in  = c_next;
                  row_in  = r_cur;
                  slot_in = slot_cur;
               end
               if (has_out) begin
                  base_col_in  = c_cur - pad2;
                  base_slot_in = SLOT_W'(slot_wide);
                  last_in      = (c_cur == pw - 1'b1) && (r_cur == ph - 1'b1);
                  tx_in        = s_eff;
                  ty_in        = s_eff;
                  dx_in        = '0;
                  dy_in        = '0;
                  wt_in        = '0;
                  wtd_in       = '0;
                  state_in     = S_LOAD;
               end
            end
         end
         S_LOAD, S_SAD: begin
            rd_vld_in  = 1'b1;
            rd_load_in = (state_ff == S_LOAD);
            rd_ctr_in  = (dx_ff == PSPAN_W'(pr_eff)) && (dy_ff == PSPAN_W'(pr_eff));
            if (dx_ff == pspan_m1) begin
               dx_in = '0;
               if (dy_ff == pspan_m1) begin
                  dy_in    = '0;
                  state_in = S_DRAIN;
               end else begin
                  dy_in = dy_ff + 1'b1;
               end
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (rd_load_ff) begin
               tx_in    = '0;
               ty_in    = '0;
               d_in     = '0;
               state_in = S_SAD;
            end else begin
               state_in = S_WX;
            end
         end
         S_WX: begin
            mul_start = 1'b1;
            mul_a     = inv_cfg_ff;
            mul_b     = 32'(d_ff);
            state_in  = S_WXW;
         end
         S_WXW: begin
            if (mul_done) begin
               if (|mul_prod[63:28]) begin
                  w_in     = WF'(1);
                  state_in = S_ACC;
               end else begin
                  n_in     = mul_prod[27:24];
                  f_in     = mul_prod[23:0];
                  term_in  = Q30_ONE;
                  pos_in   = Q30_ONE;
                  neg_in   = '0;
                  k_in     = 4'd1;
                  state_in = S_TM;
               end
            end
         end
         S_TM: begin
            mul_start = 1'b1;
            mul_a     = term_ff;
            mul_b     = 32'(f_ff);
            state_in  = S_TMW;
         end
         // divide by k: shift out its power of two, multiply by the odd-part reciprocal
         S_TMW: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = 32'(mul_prod[53:24] >> tdiv_shift(k_ff));
               mul_b     = tdiv_recip(k_ff);
               state_in  = S_TDW;
            end
         end
         S_TDW: begin
            if (mul_done) begin
               term_in = 32'(tdiv_q);
               if (k_ff[0]) begin
                  neg_in = neg_ff + 32'(tdiv_q);
               end else begin
                  pos_in = pos_ff + 32'(tdiv_q);
               end
               if (k_ff == TAYLOR_TOP) begin
                  state_in = S_R;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_TM;
               end
            end
         end
         S_R: begin
            r_in     = (pos_ff > neg_ff) ? pos_ff - neg_ff : '0;
            state_in = (n_ff == '0) ? S_WF : S_EM;
         end
         S_EM: begin
            mul_start = 1'b1;
            mul_a     = r_ff;
            mul_b     = Q30_INV_E;
            state_in  = S_EMW;
         end
         S_EMW: begin
            if (mul_done) begin
               r_in     = 32'((mul_prod + Q30_HALF) >> 30);
               n_in     = n_ff - 1'b1;
               state_in = (n_ff == 4'd1) ? S_WF : S_EM;
            end
         end
         S_WF: begin
            if (w_raw > w_top) begin
               w_in = w_top[WF-1:0];
            end else if (w_raw == '0) begin
               w_in = WF'(1);
            end else begin
               w_in = w_raw[WF-1:0];
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            wt_in  = wt_ff + WT_W'(w_ff);
            wtd_in = wtd_ff + WTD_W'(w_ff) * WTD_W'(cand_ff);
            d_in   = '0;
            if (tx_ff == span_m1) begin
               tx_in = '0;
               if (ty_ff == span_m1) begin
                  state_in = S_Q;
               end else begin
                  ty_in    = ty_ff + 1'b1;
                  state_in = S_SAD;
               end
            end else begin
               tx_in    = tx_ff + 1'b1;
               state_in = S_SAD;
            end
         end
         S_Q: begin
            div_start = 1'b1;
            div_n     = DIV_N'(wtd_ff) + DIV_N'(wt_ff >> 1);
            div_d     = wt_ff;
            state_in  = S_QW;
         end
         S_QW: begin
            if (div_done) begin
               if (wt_ff == '0) begin
                  q_in = '0;
               end else if (|div_q[DIV_N-1:PIX_W]) begin
                  q_in = {PIX_W{1'b1}};
               end else begin
                  q_in = div_q[PIX_W-1:0];
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = q_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wt_ff         <= '0;
         wtd_ff        <= '0;
         width_cfg_ff  <= IMAGE_WIDTH_RESET;
         height_cfg_ff <= IMAGE_HEIGHT_RESET;
         search_cfg_ff <= SEARCH_RADIUS_RESET;
         patch_cfg_ff  <= PATCH_RADIUS_RESET;
         inv_cfg_ff    <= INV_SIGMA_SQ_RESET;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         slot_ff       <= slot_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         wt_ff         <= wt_in;
         wtd_ff        <= wtd_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         search_cfg_ff <= search_cfg_in;
         patch_cfg_ff  <= patch_cfg_in;
         inv_cfg_ff    <= inv_cfg_in;
      end
      base_col_ff  <= base_col_in;
      base_slot_ff <= base_slot_in;
      last_ff      <= last_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rd_load_ff   <= rd_load_in;
      rd_ctr_ff    <= rd_ctr_in;
      d_ff         <= d_in;
      cand_ff      <= cand_in;
      n_ff         <= n_in;
      f_ff         <= f_in;
      term_ff      <= term_in;
      pos_ff       <= pos_in;
      neg_ff       <= neg_in;
      r_ff         <= r_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      q_ff         <= q_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // line store: write on accept, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= req_tdata;
      end
      mem_q_ff <= line_mem[mem_raddr];
   end

   // centre-patch chain
   assign cell_ctl.shift = rd_vld_ff;
   assign cell_ctl.load  = rd_load_ff;

   for (genvar i = 0; i < PATCH_CELLS; i++) begin : g_cell
      logic [PIX_W-1:0] next_pix;
      if (i == PATCH_CELLS - 1) begin : g_end
         assign next_pix = cell_pix[0];
      end else begin : g_mid
         assign next_pix = cell_pix[i+1];
      end
      nlmd_patch_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .is_tail    (CELL_W'(i) == len_m1),
         .next_pixel (next_pix),
         .head_pixel (head_pix),
         .load_pixel (mem_q_ff),
         .pixel      (cell_pix[i])
      );
   end

   nlmd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   nlmd_div #(
      .N (DIV_N),
      .D (WT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### verif/nlmd_checker.sv
// Checker of the non-local-means denoiser: predicts each output pixel and compares it.
module nlmd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [nlmd_pkg::PIX_W-1:0]      req_tdata,   // padded_pixel
   input  logic                            req_tuser,   // frame_start
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [nlmd_pkg::PIX_W-1:0]      rsp_tdata,   // denoised_pixel
   input  logic                            rsp_tlast,   // frame_last
   input  logic                            csr_we,
   input  logic [nlmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nlmd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              errors,
   output int                              pending,
   output int                              checked
);
   import nlmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIM_S     = 10;
   localparam int LIM_R     = 3;
   localparam int LIM_W     = 1024;
   localparam int FRAC      = 16;
   localparam int PAD_LIM   = LIM_S + LIM_R;
   localparam int ROWS      = 2 * PAD_LIM + 1;
   localparam int COLS      = LIM_W + 2 * PAD_LIM;
   localparam longint unsigned ONE_Q30   = 64'd1073741824;
   localparam longint unsigned INV_E_Q30 = 64'd395007542;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } out_pixel_type;

   logic [IW_W-1:0] img_w;
   logic [IH_W-1:0] img_h;
   logic [SR_W-1:0] srad;
   logic [PR_W-1:0] prad;
   logic [IS_W-1:0] isq;
   int              col_pos, row_pos;
   byte unsigned    rows_mem [ROWS*COLS];
   out_pixel_type   denoised_q[$];

   function automatic int pix_at(int c, int r);
      return rows_mem[(r % ROWS) * COLS + c];
   endfunction

   // exp(-x) in Q0.16 from a Taylor series over the fraction and e^-1 steps
   function automatic longint unsigned weight(longint unsigned x);
      longint unsigned n, f, term, pos, neg, acc, w;
      n = x >> 24;
      f = x & 64'hFFFFFF;
      if (n >= 16) return 1;
      term = ONE_Q30;
      pos = ONE_Q30;
      neg = 0;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * f) >> 24) / k;
         if (k % 2 == 1) neg += term;
         else pos += term;
      end
      acc = (pos > neg) ? pos - neg : 0;
      for (int k = 0; k < n; k++) acc = (acc * INV_E_Q30 + (64'd1 << 29)) >> 30;
      w = ((acc << FRAC) + (64'd1 << 29)) >> 30;
      if (w > (64'd1 << FRAC) - 1) w = (64'd1 << FRAC) - 1;
      if (w < 1) w = 1;
      return w;
   endfunction

   function automatic int filter_at(int cx, int cy, int s, int pr);
      longint unsigned wsum, psum, w;
      int qx, qy, d, a, b, q;
      wsum = 0;
      psum = 0;
      for (int ty = -s; ty <= s; ty++)
         for (int tx = -s; tx <= s; tx++) begin
            qx = cx + tx;
            qy = cy + ty;
            d = 0;
            for (int dy = -pr; dy <= pr; dy++)
               for (int dx = -pr; dx <= pr; dx++) begin
                  a = pix_at(cx + dx, cy + dy);
                  b = pix_at(qx + dx, qy + dy);
                  d += (a > b) ? a - b : b - a;
               end
            w = weight(longint'(d) * longint'(isq));
            wsum += w;
            psum += w * pix_at(qx, qy);
         end
      if (wsum == 0) return 0;
      q = int'((psum + wsum / 2) / wsum);
      return (q > 255) ? 255 : q;
   endfunction

   // store one padded pixel, advance the raster position and queue any output
   function automatic void accept_pixel(logic [PIX_W-1:0] pix, logic sof);
      int w, h, s, pr, pad, pw, ph;
      out_pixel_type e;
      w = (img_w < 1) ? 1 : (img_w > LIM_W) ? LIM_W : img_w;
      h = (img_h < 1) ? 1 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
      s = (srad > LIM_S) ? LIM_S : srad;
      pr = prad;
      pad = s + pr;
      pw = w + 2 * pad;
      ph = h + 2 * pad;
      if (sof || col_pos >= pw || row_pos >= ph) begin
         col_pos = 0;
         row_pos = 0;
      end
      rows_mem[(row_pos % ROWS) * COLS + col_pos] = pix;
      if (col_pos >= 2 * pad && row_pos >= 2 * pad) begin
         e.pix = PIX_W'(filter_at(col_pos - pad, row_pos - pad, s, pr));
         e.last = (col_pos == pw - 1 && row_pos == ph - 1);
         denoised_q.push_back(e);
      end
      col_pos++;
      if (col_pos >= pw) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= ph) row_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      out_pixel_type e;
      if (reset) begin
         img_w = IMAGE_WIDTH_RESET;
         img_h = IMAGE_HEIGHT_RESET;
         srad = SEARCH_RADIUS_RESET;
         prad = PATCH_RADIUS_RESET;
         isq = INV_SIGMA_SQ_RESET;
         col_pos = 0;
         row_pos = 0;
         denoised_q.delete();
         errors = 0;
         checked = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w = csr_wdata[IW_W-1:0];
               CSR_IMAGE_HEIGHT:  img_h = csr_wdata[IH_W-1:0];
               CSR_SEARCH_RADIUS: srad = csr_wdata[SR_W-1:0];
               CSR_PATCH_RADIUS:  prad = csr_wdata[PR_W-1:0];
               CSR_INV_SIGMA_SQ:  isq = csr_wdata[IS_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accept_pixel(req_tdata, req_tuser);
         // compare against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (denoised_q.size() == 0) begin
               $error("unexpected output item: denoised_pixel %0d", rsp_tdata);
               errors++;
            end else begin
               e = denoised_q.pop_front();
               if (rsp_tdata !== e.pix) begin
                  $error("denoised_pixel: expected %0d, got %0d", e.pix, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("frame_last: expected %0d, got %0d", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
      pending = denoised_q.size();
   end

endmodule

### verif/tb_nonlocal_means_denoise_top.sv
// Testbench top of the non-local-means denoiser: clock, reset, frames and verdict.
module tb_nonlocal_means_denoise_top;
   import nlmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 40_000_000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;   // padded_pixel
   logic                  req_tuser = 0;    // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [PIX_W-1:0]      rsp_tdata;        // denoised_pixel
   logic                  rsp_tlast;        // frame_last
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int     errors, pending, checked;
   int     pixels_sent = 0;
   int     frames_sent = 0;
   bit     idle_on = 1;
   int     stall_left = 0;
   longint cycles = 0;

   nonlocal_means_denoise_top dut (.*);

   nlmd_checker chk (.*);

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random stall bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 0;
         stall_left--;
      end else begin
         rsp_tready = 1;
         if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      end
   end

   task automatic send_pixel(logic [PIX_W-1:0] pix, logic sof);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = pix;
      req_tuser = sof;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   // hold until every output has come and the block has settled
   task automatic drain();
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_geometry(int w, int h, int s, int pr, logic [31:0] inv);
      drain();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_SEARCH_RADIUS, s);
      write_csr(CSR_PATCH_RADIUS, pr);
      write_csr(CSR_INV_SIGMA_SQ, inv);
   endtask

   // send one padded frame, or its first cut pixels; smooth content gives varied weights
   task automatic send_frame(int w, int h, int s, int pr, int cut, bit smooth, bit restart);
      int pad, total, base, v;
      w = (w < 1) ? 1 : (w > 1024) ? 1024 : w;
      h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      s = (s > 10) ? 10 : s;
      pad = s + pr;
      total = (w + 2 * pad) * (h + 2 * pad);
      if (cut > 0 && cut < total) total = cut;
      base = $urandom_range(0, 255);
      for (int i = 0; i < total; i++) begin
         v = smooth ? base + $urandom_range(0, 24) - 12 : $urandom_range(0, 255);
         v = (v < 0) ? 0 : (v > 255) ? 255 : v;
         send_pixel(PIX_W'(v), (i == 0) || (restart && $urandom_range(0, 40) == 0));
      end
      frames_sent++;
   endtask

   function automatic logic [31:0] pick_strength();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(0, 1 << 16);
         default: return $urandom_range(1000, 200000);
      endcase
   endfunction

   initial begin
      int w, h, s, pr;
      repeat (7) @(negedge clock);
      reset = 0;

      // directed: a frame that wraps without a frame start, extreme pixels, zero strength
      set_geometry(2, 1, 0, 0, INV_SIGMA_SQ_RESET);
      send_pixel(8'd0, 1);
      send_pixel(8'd255, 0);
      send_pixel(8'd255, 0);
      send_pixel(8'd0, 0);
      set_geometry(3, 2, 0, 1, 0);
      for (int i = 0; i < 20; i++) send_pixel((i % 3 == 0) ? 8'd255 : 8'd0, i == 0);

      // out-of-range sizes, the widest line cut short, saturated radius at full window
      set_geometry(0, 0, 0, 1, 32'hFFFF_FFFF);
      send_frame(1, 1, 0, 1, 0, 0, 0);
      set_geometry(2047, 8191, 0, 0, $urandom);
      send_frame(1024, 4096, 0, 0, 40, 1, 0);
      set_geometry(1024, 4096, 1, 0, INV_SIGMA_SQ_RESET);
      send_frame(1024, 4096, 1, 0, 30, 1, 0);
      set_geometry(1, 1, 15, 3, INV_SIGMA_SQ_RESET);
      send_frame(1, 1, 15, 3, 0, 1, 0);

      // random frames, mostly small windows, with some restarts and cut frames
      while (pixels_sent < 1340) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 3);
         s = ($urandom_range(0, 3) == 0) ? 1 : 0;
         pr = $urandom_range(0, 2);
         if (pixels_sent > 1200) idle_on = 0;
         set_geometry(w, h, s, pr, pick_strength());
         send_frame(w, h, s, pr,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0,
                    1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end

      drain();
      repeat (100) @(negedge clock);
      $display("Sent %0d padded pixels in %0d frames; checked %0d output pixels.",
               pixels_sent, frames_sent, checked);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### nonlocal_means_denoise_top.f
design/nlmd_pkg.sv
design/nlmd_patch_cell.sv
design/nlmd_mul.sv
design/nlmd_div.sv
design/nonlocal_means_denoise_top.sv
verif/nlmd_checker.sv
verif/tb_nonlocal_means_denoise_top.sv
